// File: rtl/mxt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mxt_pkg
// Shared codes, defaults and types of the maximum-xor trie.
// ----------------------------------------------------------------------------
package mxt_pkg;

    // default sizes
    localparam int KEY_BITS_DEF   = 32;
    localparam int NODE_COUNT_DEF = 4096;
    localparam int COUNT_BITS_DEF = 16;

    // field widths fixed by the interface
    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;

    // request operations
    localparam logic [OP_W-1:0] OP_INS = 2'd0;
    localparam logic [OP_W-1:0] OP_DEL = 2'd1;
    localparam logic [OP_W-1:0] OP_QRY = 2'd2;
    // spare code, completes with ok and changes nothing
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

    // control of the key / result cell row
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage : mxt_pkg
`default_nettype wire

// File: rtl/mxt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mxt_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module mxt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_wr_en,
    input  wire [$clog2(DEPTH)-1:0]  i_wr_addr,
    input  wire [WIDTH-1:0]          i_wr_data,
    input  wire [$clog2(DEPTH)-1:0]  i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule : mxt_ram
`default_nettype wire

// File: rtl/mxt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mxt_cell
// One bit of the key / result row; loads a key bit or takes its neighbor.
// ----------------------------------------------------------------------------
module mxt_cell
    import mxt_pkg::*;
(
    input  wire        i_clk,
    input  t_cell_ctl  i_ctl,
    input  wire        i_load_bit,
    input  wire        i_shift_in,
    output logic       o_bit
);

    logic r_bit;

    // load from the request or shift one place toward the top
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_bit <= i_load_bit;
        end else if (i_ctl.shift) begin
            r_bit <= i_shift_in;
        end
    end

    assign o_bit = r_bit;

endmodule : mxt_cell
`default_nettype wire

// File: rtl/max_xor_trie.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_xor_trie
// Binary trie over keys holding a multiset, with insert, delete and
// maximum-xor query.
// ----------------------------------------------------------------------------
// One request is worked at a time. The key sits in a row of KEY_BITS one-bit
// cells that shifts once per trie level, so the current bit is always at the
// top; on a query the chosen result bits shift in at the bottom and the row
// ends up holding max_xor. Nodes live in one memory with one read and one
// write per cycle, and the root lives in registers. An insert level that
// allocates a fresh node passes only the step state, every other level adds
// a wait for the registered read of the child, a query level whose opposite
// child is linked but dead passes the step, opposite and same-child states,
// and a delete walks the path twice. The next request is accepted from the
// cycle in which the result is presented. No clearing pass: node entries are
// always written when allocated, before they are read.
// ----------------------------------------------------------------------------
module max_xor_trie
    import mxt_pkg::*;
#(
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire [OP_W-1:0]      i_op,
    input  wire [KEY_W-1:0]     i_key,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [KEY_W-1:0]    o_max_xor
);

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int FREE_W = IDX_W + 1;
    localparam int LVL_W  = $clog2(KEY_BITS + 1);
    localparam int NODE_W = 2 * IDX_W + COUNT_BITS;

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_START    = 15'b000000000000010,
        S_INS_STEP = 15'b000000000000100,
        S_INS_WAIT = 15'b000000000001000,
        S_INS_LEAF = 15'b000000000010000,
        S_D_STEP   = 15'b000000000100000,
        S_D_WAIT   = 15'b000000001000000,
        S_D_INIT   = 15'b000000010000000,
        S_DC_STEP  = 15'b000000100000000,
        S_DC_WAIT  = 15'b000001000000000,
        S_Q_STEP   = 15'b000010000000000,
        S_Q_OTH    = 15'b000100000000000,
        S_Q_SAME   = 15'b001000000000000,
        S_Q_FILL   = 15'b010000000000000,
        S_DONE     = 15'b100000000000000
    } t_state;

    t_state                r_state, n_state;
    logic [OP_W-1:0]       r_op, n_op;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [LVL_W-1:0]      r_cnt, n_cnt;
    logic [FREE_W-1:0]     r_next_free, n_next_free;
    logic [IDX_W-1:0]      r_root_l0, n_root_l0, r_root_l1, n_root_l1;
    logic [COUNT_BITS-1:0] r_root_cnt, n_root_cnt;
    logic                  r_cur_root, n_cur_root;
    logic [IDX_W-1:0]      r_cur_idx, n_cur_idx;
    logic [IDX_W-1:0]      r_cur_l0, n_cur_l0, r_cur_l1, n_cur_l1;
    logic [COUNT_BITS-1:0] r_cur_cnt, n_cur_cnt;
    logic                  r_o_valid, n_o_valid;
    logic [STATUS_W-1:0]   r_o_status, n_o_status;
    logic [KEY_W-1:0]      r_o_max, n_o_max;

    // cell row
    t_cell_ctl             w_ctl;
    logic                  w_shift_in;
    logic [KEY_BITS-1:0]   w_bits;
    logic [KEY_BITS-1:0]   w_key;

    // node memory
    logic                  w_wr_en;
    logic [IDX_W-1:0]      w_wr_addr, w_rd_addr;
    logic [NODE_W-1:0]     w_wr_data, w_rd_data;
    logic [IDX_W-1:0]      w_rd_l0, w_rd_l1;
    logic [COUNT_BITS-1:0] w_rd_cnt;

    // write back of the current node
    logic                  w_wb_en;
    logic [IDX_W-1:0]      w_wb_l0, w_wb_l1;
    logic [COUNT_BITS-1:0] w_wb_cnt;

    logic                  w_bit;
    logic [IDX_W-1:0]      w_same, w_other, w_free_idx;
    logic                  w_no_room;
    logic [COUNT_BITS-1:0] w_child_cnt;

    assign w_key      = KEY_BITS'(i_key);
    assign w_bit      = w_bits[KEY_BITS-1];
    assign w_same     = w_bit ? r_cur_l1 : r_cur_l0;
    assign w_other    = w_bit ? r_cur_l0 : r_cur_l1;
    assign w_free_idx = r_next_free[IDX_W-1:0];
    assign w_no_room  = (32'(r_next_free) + 32'(KEY_BITS)) > 32'(NODE_COUNT);
    assign w_rd_cnt   = w_rd_data[COUNT_BITS-1:0];
    assign w_rd_l0    = w_rd_data[COUNT_BITS +: IDX_W];
    assign w_rd_l1    = w_rd_data[COUNT_BITS + IDX_W +: IDX_W];
    assign w_child_cnt = w_rd_cnt - COUNT_BITS'(1);

    // row of key / result cells, top cell holds the current level's bit
    for (genvar g = 0; g < KEY_BITS; g++) begin : g_cell
        logic w_in;
        if (g == 0) begin : g_first
            assign w_in = w_shift_in;
        end else begin : g_rest
            assign w_in = w_bits[g-1];
        end
        mxt_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_load_bit (w_key[g]),
            .i_shift_in (w_in),
            .o_bit      (w_bits[g])
        );
    end

    mxt_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // walk sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_status    = r_status;
        n_cnt       = r_cnt;
        n_next_free = r_next_free;
        n_root_l0   = r_root_l0;
        n_root_l1   = r_root_l1;
        n_root_cnt  = r_root_cnt;
        n_cur_root  = r_cur_root;
        n_cur_idx   = r_cur_idx;
        n_cur_l0    = r_cur_l0;
        n_cur_l1    = r_cur_l1;
        n_cur_cnt   = r_cur_cnt;
        n_o_valid   = r_o_valid;
        n_o_status  = r_o_status;
        n_o_max     = r_o_max;
        w_ctl       = '0;
        w_shift_in  = w_bit;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_cur_idx;
        w_wr_data   = {r_cur_l1, r_cur_l0, r_cur_cnt};
        w_rd_addr   = w_same;
        w_wb_en     = 1'b0;
        w_wb_l0     = r_cur_l0;
        w_wb_l1     = r_cur_l1;
        w_wb_cnt    = r_cur_cnt;

        // result taken downstream
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    w_ctl.load = 1'b1;
                    n_op       = i_op;
                    n_status   = ST_OK;
                    n_cnt      = LVL_W'(KEY_BITS);
                    n_cur_root = 1'b1;
                    n_cur_l0   = r_root_l0;
                    n_cur_l1   = r_root_l1;
                    n_cur_cnt  = r_root_cnt;
                    n_state    = S_START;
                end
            end
            S_START: begin
                case (r_op)
                    OP_INS: begin
                        if ((r_root_cnt == '1) || w_no_room) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_INS_STEP;
                        end
                    end
                    OP_DEL: begin
                        if (r_root_cnt == '0) begin
                            n_status = ST_ABSENT;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_D_STEP;
                        end
                    end
                    OP_QRY: begin
                        if (r_root_cnt == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_Q_STEP;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            // insert: bump count, link a fresh node if missing, go down
            S_INS_STEP: begin
                w_wb_en     = 1'b1;
                w_wb_cnt    = r_cur_cnt + COUNT_BITS'(1);
                w_ctl.shift = 1'b1;
                n_cnt       = r_cnt - LVL_W'(1);
                n_cur_root  = 1'b0;
                if (w_same == '0) begin
                    if (w_bit) begin
                        w_wb_l1 = w_free_idx;
                    end else begin
                        w_wb_l0 = w_free_idx;
                    end
                    n_next_free = r_next_free + FREE_W'(1);
                    n_cur_idx   = w_free_idx;
                    n_cur_l0    = '0;
                    n_cur_l1    = '0;
                    n_cur_cnt   = '0;
                    n_state     = (r_cnt == LVL_W'(1)) ? S_INS_LEAF : S_INS_STEP;
                end else begin
                    w_rd_addr = w_same;
                    n_cur_idx = w_same;
                    n_state   = S_INS_WAIT;
                end
            end
            S_INS_WAIT: begin
                n_cur_l0  = w_rd_l0;
                n_cur_l1  = w_rd_l1;
                n_cur_cnt = w_rd_cnt;
                n_state   = (r_cnt == '0) ? S_INS_LEAF : S_INS_STEP;
            end
            S_INS_LEAF: begin
                w_wb_en  = 1'b1;
                w_wb_cnt = r_cur_cnt + COUNT_BITS'(1);
                n_state  = S_DONE;
            end
            // delete, first pass: check that the whole path is live
            S_D_STEP: begin
                if (w_same == '0) begin
                    n_status = ST_ABSENT;
                    n_state  = S_DONE;
                end else begin
                    w_rd_addr  = w_same;
                    n_cur_idx  = w_same;
                    n_cur_root = 1'b0;
                    n_state    = S_D_WAIT;
                end
            end
            S_D_WAIT: begin
                if (w_rd_cnt == '0) begin
                    n_status = ST_ABSENT;
                    n_state  = S_DONE;
                end else begin
                    n_cur_l0    = w_rd_l0;
                    n_cur_l1    = w_rd_l1;
                    n_cur_cnt   = w_rd_cnt;
                    w_ctl.shift = 1'b1;
                    n_cnt       = r_cnt - LVL_W'(1);
                    n_state     = (r_cnt == LVL_W'(1)) ? S_D_INIT : S_D_STEP;
                end
            end
            // delete, second pass: drop counts, cut the first dead link
            S_D_INIT: begin
                n_root_cnt = r_root_cnt - COUNT_BITS'(1);
                n_cur_root = 1'b1;
                n_cur_l0   = r_root_l0;
                n_cur_l1   = r_root_l1;
                n_cur_cnt  = r_root_cnt - COUNT_BITS'(1);
                n_cnt      = LVL_W'(KEY_BITS);
                n_state    = S_DC_STEP;
            end
            S_DC_STEP: begin
                w_rd_addr = w_same;
                n_state   = S_DC_WAIT;
            end
            S_DC_WAIT: begin
                if (w_child_cnt == '0) begin
                    w_wb_en = 1'b1;
                    if (w_bit) begin
                        w_wb_l1 = '0;
                    end else begin
                        w_wb_l0 = '0;
                    end
                    n_state = S_DONE;
                end else begin
                    w_wr_en     = 1'b1;
                    w_wr_addr   = w_same;
                    w_wr_data   = {w_rd_l1, w_rd_l0, w_child_cnt};
                    n_cur_root  = 1'b0;
                    n_cur_idx   = w_same;
                    n_cur_l0    = w_rd_l0;
                    n_cur_l1    = w_rd_l1;
                    n_cur_cnt   = w_child_cnt;
                    w_ctl.shift = 1'b1;
                    n_cnt       = r_cnt - LVL_W'(1);
                    n_state     = (r_cnt == LVL_W'(1)) ? S_DONE : S_DC_STEP;
                end
            end
            // query: prefer the opposite child, result bits enter at the bottom
            S_Q_STEP: begin
                if (w_other != '0) begin
                    w_rd_addr = w_other;
                    n_state   = S_Q_OTH;
                end else if (w_same == '0) begin
                    n_state = S_Q_FILL;
                end else begin
                    w_rd_addr   = w_same;
                    n_cur_idx   = w_same;
                    n_cur_root  = 1'b0;
                    w_shift_in  = 1'b0;
                    w_ctl.shift = 1'b1;
                    n_cnt       = r_cnt - LVL_W'(1);
                    n_state     = S_Q_SAME;
                end
            end
            S_Q_OTH: begin
                if (w_rd_cnt != '0) begin
                    n_cur_root  = 1'b0;
                    n_cur_idx   = w_other;
                    n_cur_l0    = w_rd_l0;
                    n_cur_l1    = w_rd_l1;
                    n_cur_cnt   = w_rd_cnt;
                    w_shift_in  = 1'b1;
                    w_ctl.shift = 1'b1;
                    n_cnt       = r_cnt - LVL_W'(1);
                    n_state     = (r_cnt == LVL_W'(1)) ? S_DONE : S_Q_STEP;
                end else if (w_same == '0) begin
                    n_state = S_Q_FILL;
                end else begin
                    w_rd_addr   = w_same;
                    n_cur_idx   = w_same;
                    n_cur_root  = 1'b0;
                    w_shift_in  = 1'b0;
                    w_ctl.shift = 1'b1;
                    n_cnt       = r_cnt - LVL_W'(1);
                    n_state     = S_Q_SAME;
                end
            end
            S_Q_SAME: begin
                n_cur_l0  = w_rd_l0;
                n_cur_l1  = w_rd_l1;
                n_cur_cnt = w_rd_cnt;
                n_state   = (r_cnt == '0) ? S_DONE : S_Q_STEP;
            end
            // walk ended early: remaining result bits are zero
            S_Q_FILL: begin
                w_shift_in  = 1'b0;
                w_ctl.shift = 1'b1;
                n_cnt       = r_cnt - LVL_W'(1);
                n_state     = (r_cnt == LVL_W'(1)) ? S_DONE : S_Q_FILL;
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_max    = ((r_op == OP_QRY) && (r_status == ST_OK)) ?
                                 KEY_W'(w_bits) : '0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // current node goes back to the root registers or the memory
        if (w_wb_en) begin
            if (r_cur_root) begin
                n_root_l0  = w_wb_l0;
                n_root_l1  = w_wb_l1;
                n_root_cnt = w_wb_cnt;
            end else begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_cur_idx;
                w_wr_data = {w_wb_l1, w_wb_l0, w_wb_cnt};
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_next_free <= FREE_W'(1);
            r_root_l0   <= '0;
            r_root_l1   <= '0;
            r_root_cnt  <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_next_free <= n_next_free;
            r_root_l0   <= n_root_l0;
            r_root_l1   <= n_root_l1;
            r_root_cnt  <= n_root_cnt;
            r_o_valid   <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_status   <= n_status;
        r_cur_root <= n_cur_root;
        r_cur_idx  <= n_cur_idx;
        r_cur_l0   <= n_cur_l0;
        r_cur_l1   <= n_cur_l1;
        r_cur_cnt  <= n_cur_cnt;
        r_o_status <= n_o_status;
        r_o_max    <= n_o_max;
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_o_valid;
    assign o_status  = r_o_status;
    assign o_max_xor = r_o_max;

`ifndef SYNTHESIS
    // pool allocation never runs past the memory
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_next_free) <= 32'(NODE_COUNT)))
        else $error("node pool overrun");

    // a level step only happens with levels left
    a_level_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_INS_STEP) || (r_state == S_D_STEP) || (r_state == S_DC_STEP)
         || (r_state == S_Q_STEP) || (r_state == S_Q_FILL)) |-> (r_cnt != '0))
        else $error("trie walk past the last level");

    // a finished request lands in the output register
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (!r_o_valid || i_ready)) |=> o_valid)
        else $error("result lost at completion");

    // an inserted key always leaves the set nonempty
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_INS_LEAF)) |=> (r_root_cnt != '0))
        else $error("root count zero after insert");
`endif

endmodule : max_xor_trie
`default_nettype wire

// File: tb/tb_max_xor_trie.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_xor_trie
// Self-checking bench for the maximum-xor trie: a bit-level trie copy predicts
// the status and max_xor of every request, and a result process compares them
// in order while both sides of the handshake idle at random.
// ----------------------------------------------------------------------------
module tb_max_xor_trie;
    import mxt_pkg::*;

    localparam int NODES     = NODE_COUNT_DEF;
    localparam int KBITS     = KEY_BITS_DEF;
    localparam int CNT_MAX   = (1 << COUNT_BITS_DEF) - 1;
    localparam int WDOG_MAX  = 5000;
    localparam int NKEYS     = 16;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    max_xor;
    } t_result;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                i_valid   = 1'b0;
    logic [OP_W-1:0]     i_op      = OP_INS;
    logic [KEY_W-1:0]    i_key     = '0;
    logic                i_ready   = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [KEY_W-1:0]    o_max_xor;

    max_xor_trie uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_op      (i_op),
        .i_key     (i_key),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_status  (o_status),
        .o_max_xor (o_max_xor)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // trie copy: index zero is the root
    int unsigned link0 [NODES];
    int unsigned link1 [NODES];
    int unsigned cnt   [NODES];
    int unsigned next_free = 1;

    t_result     pending_results [$];
    logic [KEY_W-1:0] key_set [NKEYS];
    int          send_idle = 0;
    int          recv_idle = 0;
    int          errors    = 0;
    int          n_requests = 0;
    int          n_results  = 0;
    int          n_full     = 0;
    int          n_absent   = 0;
    int          n_empty    = 0;
    int          wdog       = 0;

    function automatic int unsigned child_of(int unsigned n, bit b);
        return b ? link1[n] : link0[n];
    endfunction

    function automatic void set_child(int unsigned n, bit b, int unsigned c);
        if (b) link1[n] = c;
        else   link0[n] = c;
    endfunction

    // predicted result of one request, updating the trie copy
    function automatic t_result trie_apply(logic [OP_W-1:0] op, logic [KEY_W-1:0] k);
        t_result     r;
        int unsigned cur;
        int unsigned c;
        bit          b;
        bit          ok;
        r.status  = ST_OK;
        r.max_xor = '0;
        cur = 0;
        if (op == OP_INS) begin
            if (cnt[0] >= CNT_MAX || next_free + KBITS > NODES) begin
                r.status = ST_FULL;
            end else begin
                for (int i = KBITS - 1; i >= 0; i--) begin
                    b = k[i];
                    cnt[cur]++;
                    if (child_of(cur, b) == 0) begin
                        link0[next_free] = 0;
                        link1[next_free] = 0;
                        cnt[next_free]   = 0;
                        set_child(cur, b, next_free);
                        next_free++;
                    end
                    cur = child_of(cur, b);
                end
                cnt[cur]++;
            end
        end else if (op == OP_DEL) begin
            ok = (cnt[0] != 0);
            for (int i = KBITS - 1; i >= 0 && ok; i--) begin
                c = child_of(cur, k[i]);
                if (c == 0 || cnt[c] == 0) ok = 0;
                else cur = c;
            end
            if (!ok) begin
                r.status = ST_ABSENT;
            end else begin
                cur = 0;
                cnt[0]--;
                for (int i = KBITS - 1; i >= 0; i--) begin
                    c = child_of(cur, k[i]);
                    cnt[c]--;
                    if (cnt[c] == 0) begin
                        set_child(cur, k[i], 0);
                        break;
                    end
                    cur = c;
                end
            end
        end else if (op == OP_QRY) begin
            if (cnt[0] == 0) begin
                r.status = ST_EMPTY;
            end else begin
                for (int i = KBITS - 1; i >= 0; i--) begin
                    b = k[i];
                    c = child_of(cur, !b);
                    if (c != 0 && cnt[c] > 0) begin
                        r.max_xor[i] = 1'b1;
                        cur = c;
                    end else begin
                        c = child_of(cur, b);
                        if (c == 0) break;
                        cur = c;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // send one request; valid stays high across back-to-back requests
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
        t_result r;
        if ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_key   <= k;
        do @(posedge i_clk); while (!o_ready);
        r = trie_apply(op, k);
        pending_results = {pending_results, r};
        n_requests++;
    endtask

    // hold off until every result has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // result checker, receiver stalls and watchdog
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                wdog <= 0;
            end else begin
                wdog <= wdog + 1;
            end
            if (o_valid && i_ready) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    e = pending_results.pop_front();
                    if (o_status != e.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, e.status));
                    if (o_max_xor != e.max_xor)
                        report_mismatch($sformatf("max_xor %h, expected %h",
                                                  o_max_xor, e.max_xor));
                    if (e.status == ST_FULL)   n_full++;
                    if (e.status == ST_ABSENT) n_absent++;
                    if (e.status == ST_EMPTY)  n_empty++;
                end
            end
            if (wdog >= WDOG_MAX) begin
                $display("watchdog expired, no handshake for %0d cycles", WDOG_MAX);
                $display("TB_ERROR");
                $finish;
            end
        end
        i_ready <= ($urandom_range(99) >= recv_idle);
    end

    // extremes, every operation, empty set, absent key and unused op code
    task automatic test_directed();
        send_request(OP_QRY, 32'h0000_0000);
        send_request(OP_DEL, 32'h1234_5678);
        send_request(OP_NOP, 32'hFFFF_FFFF);
        send_request(OP_INS, 32'h0000_0000);
        send_request(OP_QRY, 32'hFFFF_FFFF);
        send_request(OP_QRY, 32'h0000_0000);
        send_request(OP_INS, 32'hFFFF_FFFF);
        send_request(OP_QRY, 32'h0000_0000);
        send_request(OP_QRY, 32'h8000_0001);
        send_request(OP_INS, 32'hFFFF_FFFF);
        send_request(OP_DEL, 32'hFFFF_FFFF);
        send_request(OP_QRY, 32'h0000_0000);
        send_request(OP_DEL, 32'hFFFF_FFFF);
        send_request(OP_DEL, 32'hFFFF_FFFF);
        send_request(OP_DEL, 32'hFFFF_FFFE);
        send_request(OP_INS, 32'h8000_0000);
        send_request(OP_QRY, 32'h7FFF_FFFF);
        send_request(OP_DEL, 32'h0000_0000);
        send_request(OP_DEL, 32'h8000_0000);
        send_request(OP_QRY, 32'h5555_5555);
        send_request(OP_NOP, 32'h0000_0000);
        wait_drained();
    endtask

    // mostly traffic on a small key set, some random-key noise
    task automatic test_random(input int n, input int s_pct, input int r_pct);
        int          sel;
        logic [KEY_W-1:0] k;
        send_idle = s_pct;
        recv_idle = r_pct;
        for (int j = 0; j < n; j++) begin
            sel = $urandom_range(99);
            k   = key_set[$urandom_range(NKEYS - 1)];
            if (sel < 42)      send_request(OP_INS, k);
            else if (sel < 62) send_request(OP_DEL, k);
            else if (sel < 85) send_request(OP_QRY, $urandom);
            else if (sel < 89) send_request(OP_DEL, $urandom);
            else if (sel < 93) send_request(OP_QRY, k);
            else if (sel < 96) send_request(OP_INS, k ^ (32'h1 << $urandom_range(31)));
            else               send_request(OP_NOP, $urandom);
        end
        wait_drained();
    endtask

    // fill the node pool until inserts are refused
    task automatic test_pool_full();
        send_idle = 10;
        recv_idle = 10;
        while (next_free + KBITS <= NODES) send_request(OP_INS, $urandom);
        for (int j = 0; j < 6; j++) send_request(OP_INS, $urandom);
        for (int j = 0; j < 10; j++) send_request(OP_QRY, $urandom);
        send_request(OP_DEL, key_set[0]);
        send_request(OP_INS, key_set[1]);
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < NKEYS; i++) key_set[i] = $urandom;
        key_set[0] = 32'h0000_0000;
        key_set[1] = 32'hFFFF_FFFF;
        key_set[2] = key_set[3] ^ 32'h0000_0001;
        key_set[4] = key_set[5] ^ 32'h0001_0000;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(300, 20, 67);
        test_random(300, 67, 20);
        test_random(200, 0, 0);
        test_pool_full();
        repeat (200) @(posedge i_clk);
        $display("covered %0d requests, %0d results: %0d refused full, %0d absent, %0d empty",
                 n_requests, n_results, n_full, n_absent, n_empty);
        $display("pool filled to node %0d, mismatches %0d", next_free, errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
